### sv/ycfp_pkg.sv
// Shared types, register codes and arithmetic helpers for the YUV crop framebuffer packer.
package ycfp_pkg;

  localparam int unsigned SrcW = 11;
  localparam int unsigned ScrW = 13;
  localparam int unsigned PosW = 10;
  localparam int unsigned AccW = 20;
  localparam int unsigned AddrW = 26;

  localparam logic [SrcW-1:0] SRC_DIM_MAX = 11'd1024;
  localparam logic [ScrW-1:0] SCR_DIM_MAX = 13'd4096;

  localparam logic [SrcW-1:0] RST_SRC_WIDTH = 11'd640;
  localparam logic [SrcW-1:0] RST_SRC_HEIGHT = 11'd480;
  localparam logic [SrcW-1:0] RST_WIN_WIDTH = 11'd240;
  localparam logic [SrcW-1:0] RST_WIN_HEIGHT = 11'd135;
  localparam logic [ScrW-1:0] RST_SCR_WIDTH = 13'd240;
  localparam logic [ScrW-1:0] RST_SCR_HEIGHT = 13'd135;

  localparam logic signed [AccW-1:0] COEF_Y = 20'sd298;
  localparam logic signed [AccW-1:0] COEF_RV = 20'sd409;
  localparam logic signed [AccW-1:0] COEF_GU = 20'sd100;
  localparam logic signed [AccW-1:0] COEF_GV = 20'sd208;
  localparam logic signed [AccW-1:0] COEF_BU = 20'sd516;
  localparam logic signed [AccW-1:0] ROUND_OFS = 20'sd128;
  localparam logic [PosW-1:0] LUMA_OFS = 10'd16;
  localparam logic [PosW-1:0] CHROMA_OFS = 10'd128;

  localparam logic [2:0] BYTES_BGR0 = 3'd4;
  localparam logic [2:0] BYTES_BGR = 3'd3;
  localparam logic [2:0] BYTES_RGB565 = 3'd2;

  typedef enum logic [1:0] {
    FMT_BGR0   = 2'd0,
    FMT_BGR    = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_NONE   = 2'd3
  } pix_fmt_e;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_WIN_WIDTH  = 3'd2,
    REG_WIN_HEIGHT = 3'd3,
    REG_SCR_WIDTH  = 3'd4,
    REG_SCR_HEIGHT = 3'd5,
    REG_PIX_FORMAT = 3'd6
  } cfg_reg_e;

  // Floor division by 256 followed by saturation to 0..255.
  function automatic logic [7:0] clamp8(logic signed [AccW-1:0] acc);
    logic signed [11:0] q;
    logic [7:0] res;
    q = acc[AccW-1:8];
    if (q < 12'sd0) begin
      res = 8'd0;
    end else if (q > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

  function automatic logic signed [AccW-1:0] sext10(logic signed [PosW-1:0] v);
    return {{(AccW-PosW){v[PosW-1]}}, v};
  endfunction

endpackage

### sv/yuv_crop_framebuffer_pack.sv
// Top level of the YUV crop framebuffer packer: position tracking, crop, color conversion, packing.
// Throughput: one item per cycle, when the output is not stalled, through four
// registered stages; the stages are the window check, the coefficient products, the stride
// multiply with clamping and the final pack. Items outside the crop window leave no result.
// Reset clears the pipeline valid bits and the position counters and loads
// the register defaults; the configuration port is always ready.
module yuv_crop_framebuffer_pack import ycfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [ScrW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        luma_i,
  input  logic [7:0]        chroma_blue_i,
  input  logic [7:0]        chroma_red_i,
  input  logic              frame_start_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [AddrW-1:0]  byte_address_o,
  output logic [31:0]       pixel_data_o,
  output logic [2:0]        byte_count_o,
  output logic              last_pixel_o
);

  logic [SrcW-1:0] src_width_q, src_height_q, win_width_q, win_height_q;
  logic [ScrW-1:0] scr_width_q, scr_height_q;
  pix_fmt_e        pix_format_q;

  logic [PosW-1:0] col_q, row_q, col_d, row_d;

  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_valid_d;
  logic out_adv, s3_ready, s2_ready, s1_ready, in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= RST_SRC_WIDTH;
      src_height_q <= RST_SRC_HEIGHT;
      win_width_q  <= RST_WIN_WIDTH;
      win_height_q <= RST_WIN_HEIGHT;
      scr_width_q  <= RST_SCR_WIDTH;
      scr_height_q <= RST_SCR_HEIGHT;
      pix_format_q <= FMT_BGR0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SrcW-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i[SrcW-1:0];
        REG_WIN_WIDTH:  win_width_q  <= cfg_data_i[SrcW-1:0];
        REG_WIN_HEIGHT: win_height_q <= cfg_data_i[SrcW-1:0];
        REG_SCR_WIDTH:  scr_width_q  <= cfg_data_i;
        REG_SCR_HEIGHT: scr_height_q <= cfg_data_i;
        REG_PIX_FORMAT: pix_format_q <= pix_fmt_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Effective dimensions and window placement.
  logic [SrcW-1:0] sw_eff, sh_eff, cx_end, cy_end;
  logic [ScrW-1:0] scw_eff, sch_eff, scx_diff, scy_diff;
  logic [SrcW-1:0] cx_diff, cy_diff;
  logic [PosW-1:0] cx, cy;
  logic [ScrW-1:0] off_x, off_y;
  logic            crop_en;

  always_comb begin
    sw_eff  = (src_width_q > SRC_DIM_MAX) ? SRC_DIM_MAX : src_width_q;
    sh_eff  = (src_height_q > SRC_DIM_MAX) ? SRC_DIM_MAX : src_height_q;
    scw_eff = (scr_width_q > SCR_DIM_MAX) ? SCR_DIM_MAX : scr_width_q;
    sch_eff = (scr_height_q > SCR_DIM_MAX) ? SCR_DIM_MAX : scr_height_q;
    crop_en = (pix_format_q != FMT_NONE) && (win_width_q != '0) && (win_height_q != '0)
              && (sw_eff >= win_width_q) && (sh_eff >= win_height_q)
              && (scw_eff >= {2'b00, win_width_q}) && (sch_eff >= {2'b00, win_height_q});
    cx_diff  = sw_eff - win_width_q;
    cy_diff  = sh_eff - win_height_q;
    cx       = cx_diff[SrcW-1:1];
    cy       = cy_diff[SrcW-1:1];
    cx_end   = {1'b0, cx} + win_width_q;
    cy_end   = {1'b0, cy} + win_height_q;
    scx_diff = scw_eff - {2'b00, win_width_q};
    scy_diff = sch_eff - {2'b00, win_height_q};
    off_x    = {1'b0, scx_diff[ScrW-1:1]};
    off_y    = {1'b0, scy_diff[ScrW-1:1]};
  end

  // Stage 0: position of the current item and window check.
  logic [PosW-1:0] col_cur, row_cur, x_d, y_d;
  logic            in_win, last_d;

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    if (({1'b0, col_cur} + 11'd1) >= sw_eff) begin
      col_d = '0;
      row_d = (({1'b0, row_cur} + 11'd1) >= sh_eff) ? '0 : row_cur + 10'd1;
    end else begin
      col_d = col_cur + 10'd1;
      row_d = row_cur;
    end
    in_win = crop_en && (col_cur >= cx) && ({1'b0, col_cur} < cx_end)
             && (row_cur >= cy) && ({1'b0, row_cur} < cy_end);
    x_d    = col_cur - cx;
    y_d    = row_cur - cy;
    last_d = ({1'b0, col_cur} == cx_end - 11'd1) && ({1'b0, row_cur} == cy_end - 11'd1);
  end

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || out_adv;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && s1_ready;
  assign s1_valid_d = in_fire && in_win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s1_ready) begin
        s1_valid_q <= s1_valid_d;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Stage 1 registers.
  logic [7:0]      s1_luma_q, s1_cb_q, s1_cr_q;
  logic [PosW-1:0] s1_x_q, s1_y_q;
  logic            s1_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_luma_q <= luma_i;
      s1_cb_q   <= chroma_blue_i;
      s1_cr_q   <= chroma_red_i;
      s1_x_q    <= x_d;
      s1_y_q    <= y_d;
      s1_last_q <= last_d;
    end
  end

  // Stage 1 to 2: coefficient products and screen position.
  logic signed [PosW-1:0] c_s, d_s, e_s;
  logic signed [AccW-1:0] c_w, d_w, e_w, r_acc_d, g_acc_d, b_acc_d;
  logic [ScrW-1:0]        fx_d, fy_d;

  always_comb begin
    c_s     = signed'({2'b00, s1_luma_q} - LUMA_OFS);
    d_s     = signed'({2'b00, s1_cb_q} - CHROMA_OFS);
    e_s     = signed'({2'b00, s1_cr_q} - CHROMA_OFS);
    c_w     = sext10(c_s);
    d_w     = sext10(d_s);
    e_w     = sext10(e_s);
    r_acc_d = COEF_Y * c_w + COEF_RV * e_w + ROUND_OFS;
    g_acc_d = COEF_Y * c_w - COEF_GU * d_w - COEF_GV * e_w + ROUND_OFS;
    b_acc_d = COEF_Y * c_w + COEF_BU * d_w + ROUND_OFS;
    fx_d    = off_x + {3'b000, s1_x_q};
    fy_d    = off_y + {3'b000, s1_y_q};
  end

  logic signed [AccW-1:0] s2_r_acc_q, s2_g_acc_q, s2_b_acc_q;
  logic [ScrW-1:0]        s2_fx_q, s2_fy_q;
  logic                   s2_last_q;

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_r_acc_q <= r_acc_d;
      s2_g_acc_q <= g_acc_d;
      s2_b_acc_q <= b_acc_d;
      s2_fx_q    <= fx_d;
      s2_fy_q    <= fy_d;
      s2_last_q  <= s1_last_q;
    end
  end

  // Stage 2 to 3: stride multiply and channel clamping.
  logic [AddrW-1:0] idx_d;
  logic [7:0]       r_d, g_d, b_d;

  always_comb begin
    idx_d = {13'd0, s2_fy_q} * {13'd0, scw_eff} + {13'd0, s2_fx_q};
    r_d   = clamp8(s2_r_acc_q);
    g_d   = clamp8(s2_g_acc_q);
    b_d   = clamp8(s2_b_acc_q);
  end

  logic [AddrW-1:0] s3_idx_q;
  logic [7:0]       s3_r_q, s3_g_q, s3_b_q;
  logic             s3_last_q;

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      s3_idx_q  <= idx_d;
      s3_r_q    <= r_d;
      s3_g_q    <= g_d;
      s3_b_q    <= b_d;
      s3_last_q <= s2_last_q;
    end
  end

  // Stage 3 to output: byte address and packing.
  logic [AddrW-1:0] addr_d;
  logic [31:0]      data_d;
  logic [2:0]       count_d;

  always_comb begin
    unique case (pix_format_q)
      FMT_BGR0: begin
        count_d = BYTES_BGR0;
        addr_d  = {s3_idx_q[AddrW-3:0], 2'b00};
        data_d  = {8'd0, s3_r_q, s3_g_q, s3_b_q};
      end
      FMT_BGR: begin
        count_d = BYTES_BGR;
        addr_d  = {s3_idx_q[AddrW-2:0], 1'b0} + s3_idx_q;
        data_d  = {8'd0, s3_r_q, s3_g_q, s3_b_q};
      end
      FMT_RGB565: begin
        count_d = BYTES_RGB565;
        addr_d  = {s3_idx_q[AddrW-2:0], 1'b0};
        data_d  = {16'd0, s3_r_q[7:3], s3_g_q[7:2], s3_b_q[7:3]};
      end
      default: begin
        count_d = BYTES_BGR0;
        addr_d  = {s3_idx_q[AddrW-3:0], 2'b00};
        data_d  = {8'd0, s3_r_q, s3_g_q, s3_b_q};
      end
    endcase
  end

  logic [AddrW-1:0] out_addr_q;
  logic [31:0]      out_data_q;
  logic [2:0]       out_count_q;
  logic             out_last_q;

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_addr_q  <= addr_d;
      out_data_q  <= data_d;
      out_count_q <= count_d;
      out_last_q  <= s3_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_address_o = out_addr_q;
  assign pixel_data_o   = out_data_q;
  assign byte_count_o   = out_count_q;
  assign last_pixel_o   = out_last_q;

endmodule
